// File: design/fcf_pkg.sv
package fcf_pkg;

	// Field and register widths
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W    = 34;
	localparam int KL_W     = 3;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 16;

	// Default number of tap cells
	localparam int TAPS_DEF = 7;

	// Register indexes on the write port
	localparam logic [IDX_W-1:0] REG_KERNEL_LENGTH = 3'd0;
	localparam logic [IDX_W-1:0] REG_TAP0          = 3'd1;

	// Control that travels with an item between pipeline stages
	typedef struct packed {
		logic valid;
		logic final_item;
	} stage_ctl_t;

endpackage

// File: design/fcf_cell.sv
module fcf_cell import fcf_pkg::*; #(
	parameter bit HOLD = 1'b1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       clear,
	input  logic                       tap_en,
	input  logic signed [COEF_W-1:0]   tap,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic signed [PROD_W-1:0]   product_s1
);

	logic signed [PROD_W-1:0] product_c;

	// Multiply the sample seen by this cell with its coefficient
	assign product_c = tap_en ? PROD_W'(tap) * PROD_W'(sample_in) : '0;

	// Register the product on every push
	always_ff @(posedge clk) begin
		if (push) begin
			product_s1 <= product_c;
		end
	end

	// Hold one delay-line entry and hand it to the next cell
	generate
		if (HOLD) begin : g_hold
			logic signed [SAMPLE_W-1:0] hist_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					hist_q <= '0;
				end else if (push) begin
					hist_q <= clear ? '0 : sample_in;
				end
			end

			assign sample_out = hist_q;
		end else begin : g_end
			assign sample_out = '0;
		end
	endgenerate

endmodule

// File: design/fcf_sum.sv
module fcf_sum import fcf_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  stage_ctl_t               ctl_in,
	input  logic signed [PROD_W-1:0] products [0:TAPS-1],
	output logic                     in_en,
	output stage_ctl_t               ctl_out,
	output logic signed [ACC_W-1:0]  sum,
	input  logic                     out_en
);

	localparam int LEVELS = (TAPS > 1) ? $clog2(TAPS) : 0;
	localparam int P      = 1 << LEVELS;

	logic signed [ACC_W-1:0] node [0:LEVELS][0:P-1];
	logic                    vld  [0:LEVELS];
	logic                    fin  [0:LEVELS];
	logic                    en   [1:LEVELS+1];

	// Leaves: products widened, padding leaves at zero
	genvar i, l;
	generate
		for (i = 0; i < P; i++) begin : g_leaf
			if (i < TAPS) begin : g_use
				assign node[0][i] = ACC_W'(products[i]);
			end else begin : g_pad
				assign node[0][i] = '0;
			end
		end
	endgenerate

	assign vld[0]         = ctl_in.valid;
	assign fin[0]         = ctl_in.final_item;
	assign en[LEVELS + 1] = out_en;

	// One registered adder level per stage, each stage fills its own bubble
	generate
		for (l = 1; l <= LEVELS; l++) begin : g_lvl
			assign en[l] = !vld[l] || en[l + 1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld[l] <= 1'b0;
					fin[l] <= 1'b0;
				end else if (en[l]) begin
					vld[l] <= vld[l - 1];
					fin[l] <= fin[l - 1];
				end
			end

			for (i = 0; i < (P >> l); i++) begin : g_add
				always_ff @(posedge clk) begin
					if (en[l] && vld[l - 1]) begin
						node[l][i] <= node[l - 1][2 * i] + node[l - 1][2 * i + 1];
					end
				end
			end
		end
	endgenerate

	assign in_en              = en[1];
	assign ctl_out.valid      = vld[LEVELS];
	assign ctl_out.final_item = fin[LEVELS];
	assign sum                = node[LEVELS][0];

endmodule

// File: design/full_convolution_fir_unit.sv
// Channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------
// input    | in_valid / in_ready   | sample, block_end
// output   | out_valid / out_ready | result_value, final_output
// config   | wr_en (no wait)       | wr_index, wr_data
//
// One sample is taken per cycle while in_ready is high; its result passes the cell product
// registers, the adder tree levels and the output register before it is offered.
// A sample marked block_end is followed by (clamped kernel length) - 1 zero-flush pushes,
// set by the flush counter, during which in_ready is low.
// Reset clears the delay line, the taps, the flush counter and all stage valids; kernel length resets to 1.
// A stalled output fills empty stages first, then holds the pipeline.
module full_convolution_fir_unit import fcf_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       block_end,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ACC_W-1:0]    result_value,
	output logic                       final_output,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_index,
	input  logic [DATA_W-1:0]          wr_data
);

	logic [KL_W-1:0]          kl_q;
	logic signed [COEF_W-1:0] tap_q [0:TAPS-1];
	logic [KL_W-1:0]          n_use;
	logic [KL_W-1:0]          flush_q;
	logic                     flushing;
	logic                     accept;
	logic                     push;
	logic                     last_push;
	logic                     en_s1;
	logic                     v_s1_q;
	logic                     fin_s1_q;
	logic                     sum_in_en;
	logic                     out_en;
	stage_ctl_t               ctl_s1;
	stage_ctl_t               ctl_sum;
	logic signed [ACC_W-1:0]  sum;

	logic signed [SAMPLE_W-1:0] chain    [0:TAPS-1];
	logic signed [PROD_W-1:0]   products [0:TAPS-1];
	logic                       tap_en   [0:TAPS-1];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kl_q <= KL_W'(1);
		end else if (wr_en && wr_index == REG_KERNEL_LENGTH) begin
			kl_q <= wr_data[KL_W-1:0];
		end
	end

	genvar j;
	generate
		for (j = 0; j < TAPS; j++) begin : g_tap
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					tap_q[j] <= '0;
				end else if (wr_en && wr_index == REG_TAP0 + IDX_W'(j)) begin
					tap_q[j] <= wr_data[COEF_W-1:0];
				end
			end
		end
	endgenerate

	// Clamp the kernel length to the cells that exist
	always_comb begin
		priority if (kl_q == '0) begin
			n_use = KL_W'(1);
		end else if (kl_q > KL_W'(TAPS)) begin
			n_use = KL_W'(TAPS);
		end else begin
			n_use = kl_q;
		end
	end

	// Input handshake and push generation
	assign flushing  = (flush_q != '0);
	assign en_s1     = !v_s1_q || sum_in_en;
	assign in_ready  = en_s1 && !flushing;
	assign accept    = in_valid && in_ready;
	assign push      = en_s1 && (accept || flushing);
	assign last_push = flushing ? (flush_q == KL_W'(1))
	                            : (accept && block_end && n_use == KL_W'(1));
	assign chain[0]  = flushing ? '0 : sample;

	// Count the zero-flush pushes after a block end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= '0;
		end else if (push) begin
			if (flushing) begin
				flush_q <= flush_q - KL_W'(1);
			end else if (block_end && n_use != KL_W'(1)) begin
				flush_q <= n_use - KL_W'(1);
			end
		end
	end

	// Row of tap cells forming the delay line
	generate
		for (j = 0; j < TAPS; j++) begin : g_cell
			assign tap_en[j] = (KL_W'(j) < n_use);

			if (j < TAPS - 1) begin : g_mid
				fcf_cell #(.HOLD(1'b1)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.push       (push),
					.clear      (last_push),
					.tap_en     (tap_en[j]),
					.tap        (tap_q[j]),
					.sample_in  (chain[j]),
					.sample_out (chain[j + 1]),
					.product_s1 (products[j])
				);
			end else begin : g_last
				fcf_cell #(.HOLD(1'b0)) u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.push       (push),
					.clear      (last_push),
					.tap_en     (tap_en[j]),
					.tap        (tap_q[j]),
					.sample_in  (chain[j]),
					.sample_out (),
					.product_s1 (products[j])
				);
			end
		end
	endgenerate

	// Stage 1 control beside the cell products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q   <= 1'b0;
			fin_s1_q <= 1'b0;
		end else if (en_s1) begin
			v_s1_q   <= push;
			fin_s1_q <= last_push;
		end
	end

	assign ctl_s1.valid      = v_s1_q;
	assign ctl_s1.final_item = fin_s1_q;

	// Registered adder tree over the products
	fcf_sum #(.TAPS(TAPS)) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (ctl_s1),
		.products (products),
		.in_en    (sum_in_en),
		.ctl_out  (ctl_sum),
		.sum      (sum),
		.out_en   (out_en)
	);

	// Output register
	assign out_en = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			final_output <= 1'b0;
		end else if (out_en) begin
			out_valid    <= ctl_sum.valid;
			final_output <= ctl_sum.final_item;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && ctl_sum.valid) begin
			result_value <= sum;
		end
	end

endmodule

// File: design/fcf_checker.sv
module fcf_checker import fcf_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       block_end,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [ACC_W-1:0]    result_value,
	input logic                       final_output,
	input logic                       wr_en,
	input logic [IDX_W-1:0]           wr_index,
	input logic [DATA_W-1:0]          wr_data
);

	logic [KL_W-1:0] kl_q;

	// Track the kernel length from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kl_q <= KL_W'(1);
		end else if (wr_en && wr_index == REG_KERNEL_LENGTH) begin
			kl_q <= wr_data[KL_W-1:0];
		end
	end

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value)
			&& $stable(final_output))
		else $error("output item changed while stalled");

	// A multi-tap block end blocks input for the flush
	a_flush_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && block_end && kl_q > KL_W'(1) && TAPS > 1 |=> !in_ready)
		else $error("input taken during tail flush");

	// Reset empties the output
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind full_convolution_fir_unit fcf_checker #(.TAPS(TAPS)) u_fcf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.block_end    (block_end),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_value (result_value),
	.final_output (final_output),
	.wr_en        (wr_en),
	.wr_index     (wr_index),
	.wr_data      (wr_data)
);

// File: sim/full_convolution_fir_unit_tb.sv
module full_convolution_fir_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fcf_pkg::*;

	localparam int TAPS          = TAPS_DEF;
	localparam int HIST          = TAPS - 1;
	localparam int WAIT_MAX      = 17;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 41;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} sample_item_t;

	typedef struct {
		logic signed [ACC_W-1:0] value;
		logic                    fin;
	} conv_out_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample       = '0;
	logic                       block_end    = 1'b0;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic signed [ACC_W-1:0]    result_value;
	logic                       final_output;
	logic                       wr_en        = 1'b0;
	logic [IDX_W-1:0]           wr_index     = '0;
	logic [DATA_W-1:0]          wr_data      = '0;

	// Stimulus and expectation stores
	sample_item_t feed_q[$];
	conv_out_t    conv_q[$];

	// Shadow of the filter configuration and delay line
	logic [KL_W-1:0]            kern_len;
	logic signed [COEF_W-1:0]   coef [TAPS];
	logic signed [SAMPLE_W-1:0] hist [HIST];

	bit           send_idle = 1'b0;
	bit           recv_idle = 1'b0;
	bit           hold_req  = 1'b0;
	bit           hold_done = 1'b0;
	int           send_wait;
	int           recv_wait;
	int           hold_left;
	int           stall_cnt = 0;
	int           fail_cnt  = 0;
	sample_item_t drive_item;
	conv_out_t    want;

	full_convolution_fir_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.block_end    (block_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.final_output (final_output),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always #5ns clk = ~clk;

	// Number of taps the filter actually uses
	function automatic int taps_active();
		int n;
		n = (kern_len == 0) ? 1 : int'(kern_len);
		if (n > TAPS)
			n = TAPS;
		return n;
	endfunction

	// Shift one sample into the delay line and return the tap sum
	function automatic logic signed [ACC_W-1:0] shift_in(input logic signed [SAMPLE_W-1:0] x,
			input int n);
		longint acc;
		acc = longint'(coef[0]) * longint'(x);
		for (int j = 1; j < n; j++)
			acc += longint'(coef[j]) * longint'(hist[j-1]);
		for (int j = HIST - 1; j > 0; j--)
			hist[j] = hist[j-1];
		hist[0] = x;
		return acc[ACC_W-1:0];
	endfunction

	// Expected outputs for one sample, with the zero flush at block end
	task automatic predict_conv(input sample_item_t it);
		int        n;
		conv_out_t r;
		n = taps_active();
		r.value = shift_in(it.value, n);
		r.fin = it.last && (n == 1);
		conv_q.push_back(r);
		if (it.last) begin
			for (int k = 1; k < n; k++) begin
				r.value = shift_in('0, n);
				r.fin = (k == n - 1);
				conv_q.push_back(r);
			end
			for (int j = 0; j < HIST; j++)
				hist[j] = '0;
		end
	endtask

	function automatic logic [15:0] rand_word();
		logic [15:0] w;
		w = 16'($urandom());
		case ($urandom_range(0, 11))
			0, 1:    w = 16'h8000;
			2:       w = 16'h7fff;
			3:       w = '0;
			default: ;
		endcase
		return w;
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		if (idx == REG_KERNEL_LENGTH)
			kern_len = data[KL_W-1:0];
		else
			coef[idx - REG_TAP0] = data;
	endtask

	task automatic close_writes();
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Write a kernel length (random upper data bits) and random taps
	task automatic load_kernel(input logic [KL_W-1:0] kl);
		logic [DATA_W-1:0] d;
		d = 16'($urandom());
		d[KL_W-1:0] = kl;
		write_reg(REG_KERNEL_LENGTH, d);
		for (int j = 0; j < TAPS; j++)
			write_reg(REG_TAP0 + IDX_W'(j), rand_word());
		close_writes();
	endtask

	task automatic add_item(input logic [15:0] value, input logic last);
		sample_item_t it;
		it.value = value;
		it.last = last;
		feed_q.push_back(it);
	endtask

	// Wait until every item is taken and every output has come back
	task automatic settle();
		while (feed_q.size() != 0 || in_valid || conv_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random blocks; the last block may be cut off without its end mark
	task automatic random_phase(input int items);
		int left;
		int blen;
		left = items;
		while (left > 0) begin
			blen = $urandom_range(1, 12);
			for (int k = 0; k < blen && left > 0; k++) begin
				add_item(rand_word(), k == blen - 1);
				left--;
			end
		end
	endtask

	// Sender: hold each item until taken, then wait a drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			send_wait = 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				send_wait = send_idle ? $urandom_range(0, WAIT_MAX) : 0;
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (feed_q.size() != 0) begin
				drive_item = feed_q.pop_front();
				sample    <= drive_item.value;
				block_end <= drive_item.last;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: drawn stall after each item, one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (out_valid && out_ready)
				recv_wait = recv_idle ? $urandom_range(0, WAIT_MAX) : 0;
			else if (!out_ready && recv_wait > 0)
				recv_wait--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (recv_wait == 0);
			end
		end
	end

	// Predict on each accepted sample, check each accepted output
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_conv('{value: sample, last: block_end});
		if (arst_n && out_valid && out_ready) begin
			if (conv_q.size() == 0) begin
				$error("result_value %0d arrived with no output expected", result_value);
				fail_cnt++;
			end else begin
				want = conv_q.pop_front();
				if (result_value !== want.value) begin
					$error("result_value: expected %0d, got %0d", want.value, result_value);
					fail_cnt++;
				end
				if (final_output !== want.fin) begin
					$error("final_output: expected %0b, got %0b", want.fin, final_output);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on cycles with no item moving
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("full_convolution_fir_unit_tb: done, errors");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		kern_len = KL_W'(1);
		for (int j = 0; j < TAPS; j++)
			coef[j] = '0;
		for (int j = 0; j < HIST; j++)
			hist[j] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: one tap of zero
		add_item(16'h7fff, 1'b0);
		add_item(16'h8000, 1'b1);
		settle();

		// Full kernel of extreme coefficients, extreme samples, long flush
		write_reg(REG_KERNEL_LENGTH, 16'd7);
		write_reg(REG_TAP0,              16'h8000);
		write_reg(REG_TAP0 + IDX_W'(1),  16'h7fff);
		write_reg(REG_TAP0 + IDX_W'(2),  16'h8000);
		write_reg(REG_TAP0 + IDX_W'(3),  16'h8000);
		write_reg(REG_TAP0 + IDX_W'(4),  16'hffff);
		write_reg(REG_TAP0 + IDX_W'(5),  16'h0001);
		write_reg(REG_TAP0 + IDX_W'(6),  16'h7fff);
		close_writes();
		add_item(16'h8000, 1'b0);
		add_item(16'h8000, 1'b0);
		add_item(16'h7fff, 1'b0);
		add_item(16'h8000, 1'b0);
		add_item(16'h0000, 1'b0);
		add_item(16'hffff, 1'b0);
		add_item(16'h7fff, 1'b0);
		add_item(16'h0001, 1'b1);
		settle();

		// Zero kernel length acts as a single tap
		load_kernel(3'd0);
		add_item(16'h0005, 1'b0);
		add_item(16'h8000, 1'b1);
		add_item(16'h7fff, 1'b1);
		settle();

		// Single tap with block end: own output is final
		load_kernel(3'd1);
		add_item(16'h0100, 1'b1);
		settle();

		// Change the kernel length in the middle of a block
		load_kernel(3'd3);
		add_item(rand_word(), 1'b0);
		add_item(rand_word(), 1'b0);
		add_item(rand_word(), 1'b0);
		settle();
		write_reg(REG_KERNEL_LENGTH, 16'd5);
		close_writes();
		add_item(rand_word(), 1'b0);
		add_item(rand_word(), 1'b1);
		settle();

		// Random phases; phase 2 stalls the output long enough to back up the input
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0, 2:    load_kernel(3'd7);
				1:       load_kernel(3'd1);
				3:       load_kernel(3'd0);
				default: load_kernel(KL_W'($urandom_range(0, 7)));
			endcase
			send_idle <= (p == 2) ? 1'b0 : (p % 3 != 1);
			recv_idle <= (p == 2) ? 1'b0 : (p % 4 != 3);
			if (p == 2)
				hold_req <= 1'b1;
			random_phase(PHASE_ITEMS);
			settle();
		end

		if (fail_cnt == 0)
			$display("full_convolution_fir_unit_tb: done, clean");
		else
			$display("full_convolution_fir_unit_tb: done, errors");
		$finish;
	end

endmodule

// File: sim.f
design/fcf_pkg.sv
design/fcf_cell.sv
design/fcf_sum.sv
design/full_convolution_fir_unit.sv
design/fcf_checker.sv
sim/full_convolution_fir_unit_tb.sv
